// ----- src/atce_pkg.sv -----
// Shared types and constants for the text console engine.
package atce_pkg;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_PRINT,
        ACT_NL,
        ACT_CR,
        ACT_BS,
        ACT_TAB,
        ACT_UP,
        ACT_DOWN,
        ACT_RIGHT,
        ACT_HOME,
        ACT_NUM1_FIRST,
        ACT_NUM1_MORE,
        ACT_SEMI,
        ACT_NUM2_MORE,
        ACT_SEQ,
        ACT_READ
    } act_t;

    typedef struct packed {
        act_t act;
        logic n_given;
        logic m_given;
        logic load;
        logic plan_scroll;
        logic tab_step;
        logic conv_step;
        logic copy_rd;
        logic copy_wr;
        logic blank_step;
        logic init_fill;
        logic respond;
    } dp_cmd_t;

    typedef struct packed {
        logic [6:0] ch;
        logic is_read;
        logic tab_run;
        logic conv_run;
        logic copy_left;
        logic blank_left;
        logic scroll_req;
        logic out_busy;
    } dp_sts_t;

    localparam logic [1:0] CFG_TEXT_ATTR  = 2'd0;
    localparam logic [1:0] CFG_BLANK_ATTR = 2'd1;
    localparam logic [1:0] CFG_TAB_WIDTH  = 2'd2;

    localparam logic [6:0] CH_BS    = 7'h08;
    localparam logic [6:0] CH_TAB   = 7'h09;
    localparam logic [6:0] CH_NL    = 7'h0A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_ESC   = 7'h1B;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DEL   = 7'h7F;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_NINE  = 7'h39;
    localparam logic [6:0] CH_SEMI  = 7'h3B;
    localparam logic [6:0] CH_CSI   = 7'h5B;

    localparam logic [6:0] KEY_DOWN  = 7'h50;
    localparam logic [6:0] KEY_LEFT  = 7'h4B;
    localparam logic [6:0] KEY_UP    = 7'h48;
    localparam logic [6:0] KEY_RIGHT = 7'h4D;
    localparam logic [6:0] KEY_HOME  = 7'h47;

    localparam logic [6:0] SEQ_UP        = 7'h41;
    localparam logic [6:0] SEQ_DOWN      = 7'h42;
    localparam logic [6:0] SEQ_RIGHT     = 7'h43;
    localparam logic [6:0] SEQ_INS_LINE  = 7'h4C;
    localparam logic [6:0] SEQ_DEL_LINE  = 7'h4D;
    localparam logic [6:0] SEQ_INS_CHAR  = 7'h40;
    localparam logic [6:0] SEQ_DEL_CHAR  = 7'h50;
    localparam logic [6:0] SEQ_CLR_SCRN  = 7'h4A;
    localparam logic [6:0] SEQ_CLR_LINE  = 7'h4B;
    localparam logic [6:0] SEQ_POS       = 7'h48;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam logic [6:0] RESET_TAB  = 7'd8;
    localparam logic [7:0] NUM_MAX    = 8'd255;

endpackage

// ----- src/atce_ctrl.sv -----
// Controller: escape decoding and the sequencer for the cell engine.
module atce_ctrl
    import atce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PLAN,
        ST_TAB,
        ST_CONV,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_BLANK,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        ESC_NONE,
        ESC_SEEN,
        ESC_CSI,
        ESC_NUM1,
        ESC_NUM2
    } esc_t;

    state_t state_reg, state_next;
    esc_t   esc_reg, esc_next;
    esc_t   dec_esc;
    act_t   dec_act;
    logic   dec_n;
    logic   dec_m;
    logic   digit;

    assign digit = (sts.ch >= CH_ZERO) && (sts.ch <= CH_NINE);

    always_comb
    begin
        dec_act = ACT_NONE;
        dec_n   = 1'b0;
        dec_m   = 1'b0;
        dec_esc = esc_reg;
        if (sts.is_read)
        begin
            dec_act = ACT_READ;
        end
        else
        begin
            unique case (esc_reg)
                ESC_NONE:
                begin
                    if (sts.ch >= CH_SPACE && sts.ch < CH_DEL)
                        dec_act = ACT_PRINT;
                    else if (sts.ch == CH_NL)
                        dec_act = ACT_NL;
                    else if (sts.ch == CH_CR)
                        dec_act = ACT_CR;
                    else if (sts.ch == CH_BS)
                        dec_act = ACT_BS;
                    else if (sts.ch == CH_TAB)
                        dec_act = ACT_TAB;
                    else if (sts.ch == CH_ESC)
                        dec_esc = ESC_SEEN;
                end
                ESC_SEEN:
                begin
                    dec_esc = ESC_NONE;
                    unique case (sts.ch)
                        KEY_DOWN:  dec_act = ACT_DOWN;
                        KEY_LEFT:  dec_act = ACT_BS;
                        KEY_UP:    dec_act = ACT_UP;
                        KEY_RIGHT: dec_act = ACT_RIGHT;
                        KEY_HOME:  dec_act = ACT_HOME;
                        CH_CSI:    dec_esc = ESC_CSI;
                        default:   dec_act = ACT_NONE;
                    endcase
                end
                ESC_CSI:
                begin
                    if (digit)
                    begin
                        dec_act = ACT_NUM1_FIRST;
                        dec_esc = ESC_NUM1;
                    end
                    else
                    begin
                        dec_act = ACT_SEQ;
                        dec_esc = ESC_NONE;
                    end
                end
                ESC_NUM1:
                begin
                    if (digit)
                    begin
                        dec_act = ACT_NUM1_MORE;
                    end
                    else if (sts.ch == CH_SEMI)
                    begin
                        dec_act = ACT_SEMI;
                        dec_esc = ESC_NUM2;
                    end
                    else
                    begin
                        dec_act = ACT_SEQ;
                        dec_n   = 1'b1;
                        dec_esc = ESC_NONE;
                    end
                end
                ESC_NUM2:
                begin
                    if (digit)
                    begin
                        dec_act = ACT_NUM2_MORE;
                    end
                    else
                    begin
                        dec_act = ACT_SEQ;
                        dec_n   = 1'b1;
                        dec_m   = 1'b1;
                        dec_esc = ESC_NONE;
                    end
                end
                default:
                begin
                    dec_esc = ESC_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.act    = ACT_NONE;
        state_next = state_reg;
        esc_next   = esc_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.blank_left)
                begin
                    cmd.blank_step = 1'b1;
                    cmd.init_fill  = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.act     = dec_act;
                cmd.n_given = dec_n;
                cmd.m_given = dec_m;
                esc_next    = dec_esc;
                state_next  = ST_PLAN;
            end
            ST_PLAN:
            begin
                if (sts.tab_run)
                    state_next = ST_TAB;
                else if (sts.conv_run)
                    state_next = ST_CONV;
                else if (sts.copy_left)
                    state_next = ST_COPY_RD;
                else if (sts.blank_left)
                    state_next = ST_BLANK;
                else if (sts.scroll_req)
                    cmd.plan_scroll = 1'b1;
                else
                    state_next = ST_RESP;
            end
            ST_TAB:
            begin
                cmd.tab_step = 1'b1;
                if (!sts.tab_run)
                    state_next = ST_PLAN;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (!sts.conv_run)
                    state_next = ST_PLAN;
            end
            ST_COPY_RD:
            begin
                if (sts.copy_left)
                begin
                    cmd.copy_rd = 1'b1;
                    state_next  = ST_COPY_WR;
                end
                else
                begin
                    state_next = ST_PLAN;
                end
            end
            ST_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                state_next  = ST_COPY_RD;
            end
            ST_BLANK:
            begin
                if (sts.blank_left)
                    cmd.blank_step = 1'b1;
                else
                    state_next = ST_PLAN;
            end
            ST_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.respond = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            esc_reg   <= ESC_NONE;
        end
        else
        begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

// ----- src/atce_datapath.sv -----
// Datapath: cell store, cursor, numbers, copy and blank engines, result register.
module atce_datapath
    import atce_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25,
    localparam int TOTAL = ROWS * COLS,
    localparam int AW = $clog2(TOTAL)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  dp_cmd_t       cmd,
    output dp_sts_t       sts,
    input  logic          operation,
    input  logic [7:0]    char_code,
    input  logic [AW-1:0] cell_index,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [AW-1:0] cursor_pos,
    output logic [7:0]    cell_char,
    output logic [7:0]    cell_attr,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data
);

    localparam int CNTW = $clog2(TOTAL + 1);
    localparam int CW   = $clog2(COLS);
    localparam int RW   = $clog2(ROWS + 17);
    localparam int RMW  = $clog2(TOTAL + COLS + 128);
    localparam int WW   = $clog2(COLS * COLS + TOTAL + 1);
    localparam int PW   = WW + 1;

    logic [15:0]     mem [TOTAL];
    logic [15:0]     rd_reg;
    logic            we;
    logic [AW-1:0]   wa;
    logic [15:0]     wd;
    logic            re;
    logic [AW-1:0]   ra;

    logic            op_reg;
    logic [6:0]      ch_reg;
    logic [AW-1:0]   idx_reg;

    logic [7:0]      text_attr_reg, text_attr_next;
    logic [7:0]      blank_attr_reg, blank_attr_next;
    logic [6:0]      tab_width_reg, tab_width_next;

    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [7:0]      first_reg, first_next;
    logic [7:0]      second_reg, second_next;
    logic [AW-1:0]   src_reg, src_next;
    logic [AW-1:0]   dst_reg, dst_next;
    logic [CNTW-1:0] copy_cnt_reg, copy_cnt_next;
    logic            down_reg, down_next;
    logic [AW-1:0]   blank_addr_reg, blank_addr_next;
    logic [CNTW-1:0] blank_cnt_reg, blank_cnt_next;
    logic [RMW-1:0]  rem_reg, rem_next;
    logic            tab_run_reg, tab_run_next;
    logic            conv_run_reg, conv_run_next;
    logic            scroll_req_reg, scroll_req_next;
    logic            oob_reg, oob_next;
    logic            out_valid_reg, out_valid_next;
    logic [AW-1:0]   cursor_pos_reg, cursor_pos_next;
    logic [7:0]      cell_char_reg, cell_char_next;
    logic [7:0]      cell_attr_reg, cell_attr_next;

    logic [AW-1:0]   row_start;
    logic [AW-1:0]   lin;
    logic [7:0]      n_raw;
    logic [7:0]      n;
    logic [7:0]      m;
    logic [WW-1:0]   n_cols;
    logic [CW:0]     newc;
    logic [CW:0]     rest;
    logic [11:0]     acc1;
    logic [11:0]     acc2;
    logic [7:0]      sat1;
    logic [7:0]      sat2;
    logic [3:0]      dig;
    logic [6:0]      tw;
    logic signed [PW-1:0] pos_s;

    assign row_start = AW'(32'(row_reg) * COLS);
    assign lin       = row_start + AW'(col_reg);
    assign n_raw     = cmd.n_given ? first_reg : 8'd1;
    assign n         = (32'(n_raw) > COLS) ? 8'(COLS) : n_raw;
    assign m         = cmd.m_given ? second_reg : 8'd1;
    assign n_cols    = WW'(32'(n) * COLS);
    assign newc      = (CW + 1)'(col_reg) + (CW + 1)'(n);
    assign rest      = (CW + 1)'(COLS) - (CW + 1)'(col_reg);
    assign dig       = ch_reg[3:0];
    assign acc1      = 12'(first_reg) * 12'd10 + 12'(dig);
    assign acc2      = 12'(second_reg) * 12'd10 + 12'(dig);
    assign sat1      = (acc1 > 12'(NUM_MAX)) ? NUM_MAX : acc1[7:0];
    assign sat2      = (acc2 > 12'(NUM_MAX)) ? NUM_MAX : acc2[7:0];
    assign tw        = (tab_width_reg == 7'd0) ? 7'd1 : tab_width_reg;
    assign pos_s     = signed'(PW'(n_cols)) + signed'(PW'(m)) - signed'(PW'(COLS + 1));

    always_comb
    begin
        text_attr_next  = text_attr_reg;
        blank_attr_next = blank_attr_reg;
        tab_width_next  = tab_width_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        copy_cnt_next   = copy_cnt_reg;
        down_next       = down_reg;
        blank_addr_next = blank_addr_reg;
        blank_cnt_next  = blank_cnt_reg;
        rem_next        = rem_reg;
        tab_run_next    = tab_run_reg;
        conv_run_next   = conv_run_reg;
        scroll_req_next = scroll_req_reg;
        oob_next        = oob_reg;
        out_valid_next  = out_valid_reg;
        cursor_pos_next = cursor_pos_reg;
        cell_char_next  = cell_char_reg;
        cell_attr_next  = cell_attr_reg;
        we = 1'b0;
        wa = lin;
        wd = {text_attr_reg, 1'b0, ch_reg};
        re = 1'b0;
        ra = src_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TEXT_ATTR:  text_attr_next  = cfg_data;
                CFG_BLANK_ATTR: blank_attr_next = cfg_data;
                CFG_TAB_WIDTH:  tab_width_next  = cfg_data[6:0];
                default:        text_attr_next  = text_attr_reg;
            endcase
        end

        unique case (cmd.act)
            ACT_PRINT:
            begin
                we = 1'b1;
                if (32'(col_reg) == COLS - 1)
                begin
                    col_next = '0;
                    if (32'(row_reg) == ROWS - 1)
                        scroll_req_next = 1'b1;
                    else
                        row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            ACT_NL:
            begin
                col_next = '0;
                if (32'(row_reg) == ROWS - 1)
                    scroll_req_next = 1'b1;
                else
                    row_next = row_reg + RW'(1);
            end
            ACT_CR:
            begin
                col_next = '0;
            end
            ACT_BS:
            begin
                if (col_reg != '0)
                begin
                    col_next = col_reg - CW'(1);
                end
                else if (row_reg != '0)
                begin
                    row_next = row_reg - RW'(1);
                    col_next = CW'(COLS - 1);
                end
            end
            ACT_TAB:
            begin
                rem_next     = '0;
                tab_run_next = 1'b1;
            end
            ACT_UP:
            begin
                if (row_reg != '0)
                    row_next = row_reg - RW'(1);
            end
            ACT_DOWN:
            begin
                if (32'(row_reg) < ROWS - 1)
                    row_next = row_reg + RW'(1);
            end
            ACT_RIGHT:
            begin
                if (32'(col_reg) < COLS - 1)
                begin
                    col_next = col_reg + CW'(1);
                end
                else if (32'(row_reg) < ROWS - 1)
                begin
                    row_next = row_reg + RW'(1);
                    col_next = '0;
                end
            end
            ACT_HOME:
            begin
                row_next = '0;
                col_next = '0;
            end
            ACT_NUM1_FIRST:
            begin
                first_next = 8'(dig);
            end
            ACT_NUM1_MORE:
            begin
                first_next = sat1;
            end
            ACT_SEMI:
            begin
                second_next = '0;
            end
            ACT_NUM2_MORE:
            begin
                second_next = sat2;
            end
            ACT_READ:
            begin
                oob_next = (32'(idx_reg) >= TOTAL);
                re       = (32'(idx_reg) < TOTAL);
                ra       = idx_reg;
            end
            ACT_SEQ:
            begin
                unique case (ch_reg)
                    SEQ_UP:
                    begin
                        if (32'(n) >= 32'(row_reg))
                            row_next = '0;
                        else
                            row_next = row_reg - RW'(n);
                    end
                    SEQ_DOWN:
                    begin
                        if (32'(n) >= ROWS - 1 - 32'(row_reg))
                            row_next = RW'(ROWS - 1);
                        else
                            row_next = row_reg + RW'(n);
                    end
                    SEQ_RIGHT:
                    begin
                        if (32'(newc) >= COLS)
                        begin
                            if (32'(row_reg) == ROWS - 1)
                            begin
                                col_next = CW'(COLS - 1);
                            end
                            else
                            begin
                                row_next = row_reg + RW'(1);
                                col_next = CW'(32'(newc) - COLS);
                            end
                        end
                        else
                        begin
                            col_next = CW'(newc);
                        end
                    end
                    SEQ_INS_LINE:
                    begin
                        if (n != 8'd0)
                        begin
                            if (32'(n) >= ROWS - 32'(row_reg))
                            begin
                                blank_addr_next = row_start;
                                blank_cnt_next  = CNTW'(TOTAL - 32'(row_start));
                            end
                            else
                            begin
                                down_next       = 1'b1;
                                dst_next        = AW'(TOTAL - 1);
                                src_next        = AW'(TOTAL - 1 - 32'(n_cols));
                                copy_cnt_next   = CNTW'(TOTAL - 32'(row_start)
                                                        - 32'(n_cols));
                                blank_addr_next = row_start;
                                blank_cnt_next  = CNTW'(n_cols);
                            end
                        end
                    end
                    SEQ_DEL_LINE:
                    begin
                        if (n != 8'd0)
                        begin
                            if (32'(n) >= ROWS - 32'(row_reg))
                            begin
                                blank_addr_next = row_start;
                                blank_cnt_next  = CNTW'(TOTAL - 32'(row_start));
                            end
                            else
                            begin
                                down_next       = 1'b0;
                                dst_next        = row_start;
                                src_next        = AW'(32'(row_start) + 32'(n_cols));
                                copy_cnt_next   = CNTW'(TOTAL - 32'(row_start)
                                                        - 32'(n_cols));
                                blank_addr_next = AW'(TOTAL - 32'(n_cols));
                                blank_cnt_next  = CNTW'(n_cols);
                            end
                        end
                    end
                    SEQ_INS_CHAR:
                    begin
                        if (n != 8'd0)
                        begin
                            if (32'(n) >= 32'(rest))
                            begin
                                blank_addr_next = lin;
                                blank_cnt_next  = CNTW'(rest);
                            end
                            else
                            begin
                                down_next       = 1'b1;
                                dst_next        = AW'(32'(row_start) + COLS - 1);
                                src_next        = AW'(32'(row_start) + COLS - 1 - 32'(n));
                                copy_cnt_next   = CNTW'(32'(rest) - 32'(n));
                                blank_addr_next = lin;
                                blank_cnt_next  = CNTW'(n);
                            end
                        end
                    end
                    SEQ_DEL_CHAR:
                    begin
                        if (n != 8'd0)
                        begin
                            if (32'(n) >= 32'(rest))
                            begin
                                blank_addr_next = lin;
                                blank_cnt_next  = CNTW'(rest);
                            end
                            else
                            begin
                                down_next       = 1'b0;
                                dst_next        = lin;
                                src_next        = AW'(32'(lin) + 32'(n));
                                copy_cnt_next   = CNTW'(32'(rest) - 32'(n));
                                blank_addr_next = AW'(32'(row_start) + COLS - 32'(n));
                                blank_cnt_next  = CNTW'(n);
                            end
                        end
                    end
                    SEQ_CLR_SCRN:
                    begin
                        if (n == 8'd1)
                        begin
                            blank_addr_next = lin;
                            blank_cnt_next  = CNTW'(TOTAL - 32'(lin));
                        end
                        else
                        begin
                            blank_addr_next = '0;
                            blank_cnt_next  = CNTW'(TOTAL);
                            row_next        = '0;
                            col_next        = '0;
                        end
                    end
                    SEQ_CLR_LINE:
                    begin
                        blank_addr_next = lin;
                        blank_cnt_next  = CNTW'(rest);
                    end
                    SEQ_POS:
                    begin
                        if (pos_s[PW-1])
                        begin
                            row_next = '0;
                            col_next = '0;
                        end
                        else if (pos_s >= signed'(PW'(TOTAL)))
                        begin
                            row_next = RW'(ROWS - 1);
                            col_next = '0;
                        end
                        else
                        begin
                            rem_next      = RMW'(pos_s);
                            row_next      = '0;
                            conv_run_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        row_next = row_reg;
                    end
                endcase
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase

        if (cmd.plan_scroll)
        begin
            down_next       = 1'b0;
            src_next        = AW'(COLS);
            dst_next        = '0;
            copy_cnt_next   = CNTW'(TOTAL - COLS);
            blank_addr_next = AW'(TOTAL - COLS);
            blank_cnt_next  = CNTW'(COLS);
            scroll_req_next = 1'b0;
        end

        if (cmd.tab_step && tab_run_reg)
        begin
            if (rem_reg <= RMW'(col_reg))
            begin
                rem_next = rem_reg + RMW'(tw);
            end
            else
            begin
                tab_run_next  = 1'b0;
                conv_run_next = 1'b1;
            end
        end

        if (cmd.conv_step && conv_run_reg)
        begin
            if (32'(rem_reg) >= COLS)
            begin
                rem_next = rem_reg - RMW'(COLS);
                row_next = row_reg + RW'(1);
            end
            else
            begin
                conv_run_next = 1'b0;
                col_next      = CW'(rem_reg);
                if (32'(row_reg) >= ROWS)
                begin
                    row_next        = RW'(ROWS - 1);
                    col_next        = '0;
                    scroll_req_next = 1'b1;
                end
            end
        end

        if (cmd.copy_rd && copy_cnt_reg != '0)
        begin
            re = 1'b1;
            ra = src_reg;
        end

        if (cmd.copy_wr)
        begin
            we            = 1'b1;
            wa            = dst_reg;
            wd            = rd_reg;
            copy_cnt_next = copy_cnt_reg - CNTW'(1);
            if (down_reg)
            begin
                src_next = src_reg - AW'(1);
                dst_next = dst_reg - AW'(1);
            end
            else
            begin
                src_next = src_reg + AW'(1);
                dst_next = dst_reg + AW'(1);
            end
        end

        if (cmd.blank_step && blank_cnt_reg != '0)
        begin
            we              = 1'b1;
            wa              = blank_addr_reg;
            wd              = cmd.init_fill ? {RESET_ATTR, BLANK_CHAR}
                                            : {blank_attr_reg, BLANK_CHAR};
            blank_addr_next = blank_addr_reg + AW'(1);
            blank_cnt_next  = blank_cnt_reg - CNTW'(1);
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cmd.respond)
        begin
            out_valid_next  = 1'b1;
            cursor_pos_next = lin;
            if (op_reg && !oob_reg)
            begin
                cell_char_next = rd_reg[7:0];
                cell_attr_next = rd_reg[15:8];
            end
            else
            begin
                cell_char_next = '0;
                cell_attr_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rd_reg <= mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            ch_reg  <= char_code[6:0];
            idx_reg <= cell_index;
        end
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        down_reg        <= down_next;
        rem_reg         <= rem_next;
        cursor_pos_reg  <= cursor_pos_next;
        cell_char_reg   <= cell_char_next;
        cell_attr_reg   <= cell_attr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg  <= RESET_ATTR;
            blank_attr_reg <= RESET_ATTR;
            tab_width_reg  <= RESET_TAB;
            row_reg        <= '0;
            col_reg        <= '0;
            first_reg      <= '0;
            second_reg     <= '0;
            copy_cnt_reg   <= '0;
            blank_addr_reg <= '0;
            blank_cnt_reg  <= CNTW'(TOTAL);
            tab_run_reg    <= 1'b0;
            conv_run_reg   <= 1'b0;
            scroll_req_reg <= 1'b0;
            oob_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            text_attr_reg  <= text_attr_next;
            blank_attr_reg <= blank_attr_next;
            tab_width_reg  <= tab_width_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            copy_cnt_reg   <= copy_cnt_next;
            blank_addr_reg <= blank_addr_next;
            blank_cnt_reg  <= blank_cnt_next;
            tab_run_reg    <= tab_run_next;
            conv_run_reg   <= conv_run_next;
            scroll_req_reg <= scroll_req_next;
            oob_reg        <= oob_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign sts.ch         = ch_reg;
    assign sts.is_read    = op_reg;
    assign sts.tab_run    = tab_run_reg;
    assign sts.conv_run   = conv_run_reg;
    assign sts.copy_left  = (copy_cnt_reg != '0);
    assign sts.blank_left = (blank_cnt_reg != '0);
    assign sts.scroll_req = scroll_req_reg;
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign cell_char  = cell_char_reg;
    assign cell_attr  = cell_attr_reg;

endmodule

// ----- src/ansi_text_console_engine_core.sv -----
// Top level of the text console engine: controller plus datapath.
//
// Input channel (in_valid/in_ready): one beat is one item, either a byte
// to consume (operation 0) or a cell read (operation 1). Output channel
// (out_valid/out_ready): one beat per item with the cursor position and,
// on reads, the cell's character and attribute. Configuration channel
// (cfg_valid/cfg_ready) writes text_attr, blank_attr or tab_width and is
// always ready; write it only while no item is in flight.
// Items are handled one at a time. A plain byte or read passes through
// the decode, plan and response states from accept to the output beat.
// Tab walks the tab stops and then converts the result into lines and a
// column; cursor positioning walks row by row. Line and character
// insert/delete and scrolls walk the store one cell at a time, reading
// and then writing each moved cell, then writing each blanked cell.
// After reset all ROWS*COLS cells of the store are blanked, one cell per
// cycle, before in_ready rises.
// A stalled output beat holds; the next item is taken in the meantime and
// waits for the output register before its own beat is shown.
module ansi_text_console_engine_core
    import atce_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25,
    localparam int AW = $clog2(SCREEN_ROWS * SCREEN_COLS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          operation,
    input  logic [7:0]    char_code,
    input  logic [AW-1:0] cell_index,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [AW-1:0] cursor_pos,
    output logic [7:0]    cell_char,
    output logic [7:0]    cell_attr,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    atce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atce_datapath #(
        .COLS (SCREEN_COLS),
        .ROWS (SCREEN_ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (operation),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_pos (cursor_pos),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

endmodule
